// ===== rtl/slpc_pkg.sv =====
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and codes of the short/long press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned POT_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] PRESS_THRESHOLD_RESET = 16'd500;
    localparam logic [CFG_W-1:0] TURN_BLOCK_RESET      = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_BLOCK      = 1'b1;

    localparam logic BTN_ENCODER = 1'b0;
    localparam logic BTN_POT     = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_TURN    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_ev_t;

    typedef struct packed {
        op_t               operation;
        logic              button;
        logic [TIME_W-1:0] now_ms;
        logic [POT_W-1:0]  pot_value;
    } item_t;

    typedef struct packed {
        press_ev_t        encoder_event;
        press_ev_t        pot_event;
        logic             turn_pass;
        logic [POT_W-1:0] turn_value;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/slpc_switch.sv =====
// ----------------------------------------------------------------------------
// slpc_switch
// Push time and long-press flag of one switch; classifies its presses.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_switch (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic                          selected,
    input  wire slpc_pkg::item_t               item,
    input  wire logic [slpc_pkg::CFG_W-1:0]    threshold,
    output slpc_pkg::press_ev_t                sw_event,
    output logic                               held
);
    import slpc_pkg::*;

    logic [TIME_W-1:0] down_reg;
    logic [TIME_W-1:0] down_next;
    logic              done_reg;
    logic              done_next;
    logic [TIME_W-1:0] held_ms;
    logic              long_reached;

    assign held         = (down_reg != '0);
    assign held_ms      = item.now_ms - down_reg;
    assign long_reached = (held_ms >= {{(TIME_W-CFG_W){1'b0}}, threshold});

    always_comb begin
        down_next = down_reg;
        done_next = done_reg;
        sw_event  = EV_NONE;
        unique case (item.operation)
            OP_PUSH: begin
                if (selected) begin
                    down_next = item.now_ms;
                end
            end
            OP_RELEASE: begin
                if (selected && held) begin
                    if (long_reached) begin
                        done_next = 1'b0;
                    end else begin
                        sw_event = EV_SHORT;
                    end
                    down_next = '0;
                end
            end
            OP_TICK: begin
                if (held && !done_reg && long_reached) begin
                    done_next = 1'b1;
                    sw_event  = EV_LONG;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg <= '0;
            done_reg <= 1'b0;
        end else if (step) begin
            down_reg <= down_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slpc_turn_guard.sv =====
// ----------------------------------------------------------------------------
// slpc_turn_guard
// Blocks pot turns while the pot switch is held and for a window after it
// is released.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_turn_guard (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire slpc_pkg::item_t               item,
    input  wire logic                          pot_held,
    input  wire logic [slpc_pkg::CFG_W-1:0]    block_ms,
    output logic                               turn_pass,
    output logic [slpc_pkg::POT_W-1:0]         turn_value
);
    import slpc_pkg::*;

    logic [TIME_W-1:0] until_reg;
    logic              pot_release;

    assign pot_release = (item.operation == OP_RELEASE) && (item.button == BTN_POT)
                         && pot_held;
    assign turn_pass   = (item.operation == OP_TURN) && !pot_held
                         && (until_reg <= item.now_ms);
    assign turn_value  = turn_pass ? item.pot_value : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            until_reg <= '0;
        end else if (step && pot_release) begin
            until_reg <= item.now_ms + {{(TIME_W-CFG_W){1'b0}}, block_ms};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/short_long_press_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// short_long_press_classifier_unit
// Short/long press classifier for the encoder and pot switches with a pot
// turn guard.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_*) carry an operation (push, release, tick, pot turn),
//   the switch, the running time in ms and the pot position. Every word
//   yields exactly one result word (m_*) with the encoder and pot switch
//   events and the forwarded pot turn.
//   A word is taken into an input register, classified and written to the
//   result register. One word per cycle is sustained while m_ready stays
//   high; the combinational subtract-compare on the stored push times sets
//   this figure. When m_ready is low with a result waiting, the result
//   register holds, the input register fills and s_ready drops; nothing is
//   lost. Reset clears both push times, the long-press flags and the turn
//   window and loads a 500 ms press threshold and a 100 ms turn block
//   window. The user must write registers via cfg_wr_en/cfg_index/cfg_data
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module short_long_press_classifier_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [slpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slpc_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_operation,
    input  wire logic                              s_button,
    input  wire logic [slpc_pkg::TIME_W-1:0]       s_now_ms,
    input  wire logic [slpc_pkg::POT_W-1:0]        s_pot_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_encoder_event,
    output logic [1:0]                             m_pot_event,
    output logic                                   m_turn_pass,
    output logic [slpc_pkg::POT_W-1:0]             m_turn_value
);
    import slpc_pkg::*;

    logic [CFG_W-1:0] threshold_reg;
    logic [CFG_W-1:0] block_reg;
    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          out_next;
    logic             advance;
    logic             step;
    logic             enc_held;
    logic             pot_held;
    press_ev_t        enc_ev;
    press_ev_t        pot_ev;
    logic             pass;
    logic [POT_W-1:0] pass_value;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= PRESS_THRESHOLD_RESET;
            block_reg     <= TURN_BLOCK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PRESS_THRESHOLD: threshold_reg <= cfg_data;
                REG_TURN_BLOCK:      block_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= '{operation: op_t'(s_operation), button: s_button,
                             now_ms: s_now_ms, pot_value: s_pot_value};
        end
    end

    slpc_switch u_enc_switch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .selected  (in_item_reg.button == BTN_ENCODER),
        .item      (in_item_reg),
        .threshold (threshold_reg),
        .sw_event  (enc_ev),
        .held      (enc_held)
    );

    slpc_switch u_pot_switch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .selected  (in_item_reg.button == BTN_POT),
        .item      (in_item_reg),
        .threshold (threshold_reg),
        .sw_event  (pot_ev),
        .held      (pot_held)
    );

    slpc_turn_guard u_turn_guard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (in_item_reg),
        .pot_held   (pot_held),
        .block_ms   (block_reg),
        .turn_pass  (pass),
        .turn_value (pass_value)
    );

    assign out_next = '{encoder_event: enc_ev, pot_event: pot_ev,
                        turn_pass: pass, turn_value: pass_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= out_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_encoder_event = out_reg.encoder_event;
    assign m_pot_event     = out_reg.pot_event;
    assign m_turn_pass     = out_reg.turn_pass;
    assign m_turn_value    = out_reg.turn_value;

    a_turn_no_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_turn_pass) |-> (m_encoder_event == EV_NONE && m_pot_event == EV_NONE))
        else $error("press event reported with a forwarded turn");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_turn_pass) |-> (m_turn_value == '0))
        else $error("turn value set without a forwarded turn");

    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("classified word lost before the result register");

    a_blocked_while_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && pot_held) |=> !out_reg.turn_pass)
        else $error("turn forwarded while the pot switch is held");

endmodule

`default_nettype wire
